/* design/bsrpi_pkg.sv */
// Shared types, codes and constants of the speed ramp and PI duty block.
// No dependencies; every other design file imports this package.
package bsrpi_pkg;

  // Moving average depth and the widths that follow from it
  localparam int AVG_DEPTH  = 6;
  localparam int POS_W      = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SPEED_W    = 16;
  localparam int RING_SUM_W = SPEED_W + $clog2(AVG_DEPTH);
  // Division by AVG_DEPTH through a rounded-up reciprocal, exact for every ring sum
  localparam int AVG_SHIFT  = RING_SUM_W + $clog2(AVG_DEPTH);
  localparam int RECIP_W    = AVG_SHIFT + 1;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

  // Controller arithmetic widths
  localparam int EDGE_W   = 8;
  localparam int RPM_W    = 14;
  localparam int RPE_W    = 10;
  localparam int STEP_W   = 8;
  localparam int GAIN_W   = 16;
  localparam int RAMP_W   = 18;
  localparam int INTEG_W  = 19;
  localparam int ERR_W    = 18;
  localparam int ACC_W    = INTEG_W + 1;
  localparam int PPROD_W  = ERR_W + GAIN_W + 1;
  localparam int IPROD_W  = INTEG_W + GAIN_W + 1;
  localparam int NUMER_W  = IPROD_W + 1;

  // Duty scaling: numerator / DUTY_DIV, saturated at DUTY_MAX
  localparam int DUTY_W   = 7;
  localparam int DUTY_DIV = 10000;
  localparam int DUTY_MAX = 100;
  localparam int NUM_CAP  = DUTY_MAX * DUTY_DIV;
  localparam int NUM_W    = $clog2(NUM_CAP + 1);
  // Division by DUTY_DIV through a rounded-up reciprocal, exact up to NUM_CAP
  localparam int QUOT_SHIFT = 32;
  localparam int QRECIP_W   = 19;
  localparam logic [QRECIP_W-1:0] DUTY_RECIP =
    QRECIP_W'(((64'd1 << QUOT_SHIFT) + 64'(DUTY_DIV) - 64'd1) / 64'(DUTY_DIV));

  typedef logic [2:0]          op_t;
  typedef logic [RPM_W-1:0]    rpm_t;
  typedef logic [DUTY_W-1:0]   duty_t;
  typedef logic [1:0]          brake_t;
  typedef logic [SPEED_W-1:0]  speed_t;
  typedef logic [2:0]          cfg_index_t;
  typedef logic [INTEG_W-1:0]  cfg_data_t;

  // Operation codes
  localparam op_t OP_HALL   = 3'd0;
  localparam op_t OP_TICK   = 3'd1;
  localparam op_t OP_START  = 3'd2;
  localparam op_t OP_STOP   = 3'd3;
  localparam op_t OP_ESTOP  = 3'd4;
  localparam op_t OP_TARGET = 3'd5;

  // Brake commands
  localparam brake_t BRAKE_NONE    = 2'd0;
  localparam brake_t BRAKE_ENGAGE  = 2'd1;
  localparam brake_t BRAKE_RELEASE = 2'd2;

  // Configuration register indexes
  localparam cfg_index_t CFG_ACCEL_STEP    = 3'd0;
  localparam cfg_index_t CFG_DECEL_STEP    = 3'd1;
  localparam cfg_index_t CFG_ESTOP_STEP    = 3'd2;
  localparam cfg_index_t CFG_INTEGRAL_HIGH = 3'd3;
  localparam cfg_index_t CFG_INTEGRAL_LOW  = 3'd4;
  localparam cfg_index_t CFG_PROP_GAIN     = 3'd5;
  localparam cfg_index_t CFG_INTEG_GAIN    = 3'd6;
  localparam cfg_index_t CFG_RPM_PER_EDGE  = 3'd7;

  // Register reset values
  localparam logic [STEP_W-1:0]         RST_ACCEL_STEP    = 8'd3;
  localparam logic [STEP_W-1:0]         RST_DECEL_STEP    = 8'd6;
  localparam logic [STEP_W-1:0]         RST_ESTOP_STEP    = 8'd10;
  localparam logic [INTEG_W-2:0]        RST_INTEGRAL_HIGH = 18'd140000;
  localparam logic signed [INTEG_W-1:0] RST_INTEGRAL_LOW  = -19'sd20000;
  localparam logic [GAIN_W-1:0]         RST_PROP_GAIN     = 16'd300;
  localparam logic [GAIN_W-1:0]         RST_INTEG_GAIN    = 16'd4;
  localparam logic [RPE_W-1:0]          RST_RPM_PER_EDGE  = 10'd250;

  // Result fields that ride along the duty pipeline
  typedef struct packed {
    logic   duty_valid;
    brake_t brake_command;
    speed_t speed_now;
  } tag_t;

endpackage

/* design/bsrpi_if.sv */
// Valid/ready channels of the speed ramp and PI duty block: command requests in,
// results out. Depends on bsrpi_pkg.
interface bsrpi_cmd_if;
  import bsrpi_pkg::*;
  logic valid;
  logic ready;
  op_t  operation;
  rpm_t target_rpm;
  modport source (output valid, operation, target_rpm, input ready);
  modport sink (input valid, operation, target_rpm, output ready);
endinterface

interface bsrpi_res_if;
  import bsrpi_pkg::*;
  logic   valid;
  logic   ready;
  logic   duty_valid;
  duty_t  duty;
  brake_t brake_command;
  speed_t speed_now;
  modport source (output valid, duty_valid, duty, brake_command, speed_now, input ready);
  modport sink (input valid, duty_valid, duty, brake_command, speed_now, output ready);
endinterface

/* design/bldc_speed_ramp_pi_top.sv */
// Speed ramp and PI duty controller for a brushless motor.
// Depends on bsrpi_pkg and the channel interfaces in bsrpi_if.
//
// One request (hall edge, tick, start, stop, emergency stop, set target) is
// taken every clock cycle while cmd.ready is high, and yields exactly one
// result. All controller state (edge count, speed ring and its mean, ramp
// setpoint, integral, run flags) is updated in the cycle the request is
// taken, so requests may follow back to back. The duty value then passes a
// four-register pipeline (error and integral, the two gain products, the
// saturated numerator, the divide by 10000 into the result register); the
// pipeline advances only while the result side keeps taking results.
// Configuration writes take effect on the next request; no clearing pass follows reset.
module bldc_speed_ramp_pi_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  bsrpi_pkg::cfg_index_t cfg_index,
  input  bsrpi_pkg::cfg_data_t  cfg_data,
  bsrpi_cmd_if.sink             cmd,
  bsrpi_res_if.source           result
);
  import bsrpi_pkg::*;

  // Configuration registers
  logic [STEP_W-1:0]         accel_step;
  logic [STEP_W-1:0]         decel_step;
  logic [STEP_W-1:0]         estop_step;
  logic [INTEG_W-2:0]        integral_high;
  logic signed [INTEG_W-1:0] integral_low;
  logic [GAIN_W-1:0]         prop_gain;
  logic [GAIN_W-1:0]         integ_gain;
  logic [RPE_W-1:0]          rpm_per_edge;
  logic [RPE_W-1:0]          rpm_per_edge_next;

  // Controller state
  logic [EDGE_W-1:0]         edge_count, edge_count_next;
  speed_t                    edge_entry;
  speed_t                    speed_ring [AVG_DEPTH];
  logic [POS_W-1:0]          ring_pos, ring_pos_next;
  logic [RING_SUM_W-1:0]     ring_sum, ring_sum_next;
  speed_t                    measured_speed, measured_speed_next;
  logic signed [RAMP_W-1:0]  ramp_setpoint, ramp_setpoint_next;
  logic signed [INTEG_W-1:0] error_integral, error_integral_next;
  rpm_t                      target_speed, target_speed_next;
  logic                      running, running_next;
  logic                      emergency, emergency_next;

  logic                      fire;
  logic                      ring_we;
  logic                      duty_upd;
  logic                      down_en;
  logic [STEP_W-1:0]         down_step;
  brake_t                    brake;
  logic signed [ERR_W-1:0]   err;
  logic signed [ACC_W-1:0]   acc;
  logic signed [INTEG_W-1:0] acc_cl;
  logic [EDGE_W+RPE_W-1:0]   entry_prod;
  logic [RING_SUM_W+RECIP_W-1:0] avg_prod;
  tag_t                      tag_next;

  // Duty pipeline
  logic                      s1_valid, s2_valid, s3_valid, out_valid;
  logic                      s1_open, s2_open, s3_open, out_open;
  logic signed [ERR_W-1:0]   s1_err;
  logic signed [INTEG_W-1:0] s1_integ;
  tag_t                      s1_tag, s2_tag, s3_tag;
  logic signed [PPROD_W-1:0] s2_pprod;
  logic signed [IPROD_W-1:0] s2_iprod;
  logic [NUM_W-1:0]          s3_num;
  logic signed [NUMER_W-1:0] numer;
  logic [NUM_W-1:0]          num_sat;
  logic [NUM_W+QRECIP_W-1:0] quot_prod;
  duty_t                     quot;
  tag_t                      out_tag;
  duty_t                     out_duty;

  assign fire = cmd.valid && cmd.ready;

  // PI error and clamped integral, from the state before this request
  always_comb begin
    err = ERR_W'(ramp_setpoint) - $signed(ERR_W'({1'b0, measured_speed}));
    acc = ACC_W'(error_integral) + ACC_W'(err);
    if (acc > $signed(ACC_W'({1'b0, integral_high}))) begin
      acc_cl = $signed({1'b0, integral_high});
    end else if (acc < ACC_W'(integral_low)) begin
      acc_cl = integral_low;
    end else begin
      acc_cl = INTEG_W'(acc);
    end
  end

  always_comb begin
    edge_count_next     = edge_count;
    ring_pos_next       = ring_pos;
    ring_sum_next       = ring_sum;
    measured_speed_next = measured_speed;
    ramp_setpoint_next  = ramp_setpoint;
    error_integral_next = error_integral;
    target_speed_next   = target_speed;
    running_next        = running;
    emergency_next      = emergency;
    ring_we             = 1'b0;
    duty_upd            = 1'b0;
    down_en             = 1'b0;
    down_step           = decel_step;
    brake               = BRAKE_NONE;
    avg_prod            = '0;
    if (fire) begin
      duty_upd = (cmd.operation == OP_HALL) || (cmd.operation == OP_START) ||
                 ((cmd.operation == OP_TICK) && running && (measured_speed == '0));
      if (duty_upd) begin
        error_integral_next = acc_cl;
      end
      case (cmd.operation)
        OP_HALL: begin
          if (edge_count != '1) begin
            edge_count_next = edge_count + EDGE_W'(1);
          end
        end
        OP_TICK: begin
          if (emergency) begin
            down_en   = (ramp_setpoint >= 0);
            down_step = estop_step;
          end else if (running) begin
            if (ramp_setpoint < $signed(RAMP_W'({1'b0, target_speed}))) begin
              ramp_setpoint_next = ramp_setpoint + $signed(RAMP_W'({1'b0, accel_step}));
            end else begin
              down_en = 1'b1;
            end
          end else begin
            down_en = (ramp_setpoint >= 0);
          end
          if (down_en) begin
            ramp_setpoint_next = ramp_setpoint - $signed(RAMP_W'({1'b0, down_step}));
            if (measured_speed == '0) begin
              error_integral_next = '0;
              brake               = BRAKE_ENGAGE;
            end
          end
          // Retire the oldest ring entry, add this interval's edges, take the mean
          edge_count_next = '0;
          ring_we         = 1'b1;
          ring_sum_next   = ring_sum - RING_SUM_W'(speed_ring[ring_pos]) +
                            RING_SUM_W'(edge_entry);
          ring_pos_next   = (ring_pos == POS_W'(AVG_DEPTH - 1)) ? '0 :
                            ring_pos + POS_W'(1);
          avg_prod        = (RING_SUM_W+RECIP_W)'(ring_sum_next) *
                            (RING_SUM_W+RECIP_W)'(AVG_RECIP);
          measured_speed_next = avg_prod[AVG_SHIFT +: SPEED_W];
        end
        OP_START: begin
          brake             = BRAKE_RELEASE;
          target_speed_next = cmd.target_rpm;
          running_next      = 1'b1;
          emergency_next    = 1'b0;
        end
        OP_STOP: begin
          running_next = 1'b0;
        end
        OP_ESTOP: begin
          emergency_next = 1'b1;
          running_next   = 1'b0;
        end
        OP_TARGET: begin
          target_speed_next = cmd.target_rpm;
        end
        default: begin
        end
      endcase
    end
    tag_next.duty_valid    = duty_upd;
    tag_next.brake_command = brake;
    tag_next.speed_now     = measured_speed_next;
  end

  // Keep edge_entry equal to the saturated edge_count * rpm_per_edge at all times
  assign rpm_per_edge_next = (cfg_write && (cfg_index == CFG_RPM_PER_EDGE)) ?
                             cfg_data[RPE_W-1:0] : rpm_per_edge;
  assign entry_prod = (EDGE_W+RPE_W)'(edge_count_next) * (EDGE_W+RPE_W)'(rpm_per_edge_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_step     <= RST_ACCEL_STEP;
      decel_step     <= RST_DECEL_STEP;
      estop_step     <= RST_ESTOP_STEP;
      integral_high  <= RST_INTEGRAL_HIGH;
      integral_low   <= RST_INTEGRAL_LOW;
      prop_gain      <= RST_PROP_GAIN;
      integ_gain     <= RST_INTEG_GAIN;
      rpm_per_edge   <= RST_RPM_PER_EDGE;
      edge_count     <= '0;
      edge_entry     <= '0;
      ring_pos       <= '0;
      ring_sum       <= '0;
      measured_speed <= '0;
      ramp_setpoint  <= '0;
      error_integral <= '0;
      target_speed   <= '0;
      running        <= 1'b0;
      emergency      <= 1'b0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        speed_ring[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ACCEL_STEP:    accel_step    <= cfg_data[STEP_W-1:0];
          CFG_DECEL_STEP:    decel_step    <= cfg_data[STEP_W-1:0];
          CFG_ESTOP_STEP:    estop_step    <= cfg_data[STEP_W-1:0];
          CFG_INTEGRAL_HIGH: integral_high <= cfg_data[INTEG_W-2:0];
          CFG_INTEGRAL_LOW:  integral_low  <= $signed(cfg_data);
          CFG_PROP_GAIN:     prop_gain     <= cfg_data[GAIN_W-1:0];
          CFG_INTEG_GAIN:    integ_gain    <= cfg_data[GAIN_W-1:0];
          CFG_RPM_PER_EDGE:  rpm_per_edge  <= cfg_data[RPE_W-1:0];
          default: begin
          end
        endcase
      end
      edge_count     <= edge_count_next;
      edge_entry     <= (|entry_prod[EDGE_W+RPE_W-1:SPEED_W]) ? '1 :
                        entry_prod[SPEED_W-1:0];
      ring_pos       <= ring_pos_next;
      ring_sum       <= ring_sum_next;
      measured_speed <= measured_speed_next;
      ramp_setpoint  <= ramp_setpoint_next;
      error_integral <= error_integral_next;
      target_speed   <= target_speed_next;
      running        <= running_next;
      emergency      <= emergency_next;
      if (ring_we) begin
        speed_ring[ring_pos] <= edge_entry;
      end
    end
  end

  // Pipeline flow: a stage loads when it is empty or its content moves on
  assign out_open  = !out_valid || result.ready;
  assign s3_open   = !s3_valid || out_open;
  assign s2_open   = !s2_valid || s3_open;
  assign s1_open   = !s1_valid || s2_open;
  assign cmd.ready = s1_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_open) begin
        s1_valid <= fire;
      end
      if (s2_open) begin
        s2_valid <= s1_valid;
      end
      if (s3_open) begin
        s3_valid <= s2_valid;
      end
      if (out_open) begin
        out_valid <= s3_valid;
      end
    end
  end

  // Numerator, clipped to 0..DUTY_MAX*DUTY_DIV
  always_comb begin
    numer = NUMER_W'(s2_pprod) + NUMER_W'(s2_iprod);
    if (numer <= 0) begin
      num_sat = '0;
    end else if (numer >= NUMER_W'(NUM_CAP)) begin
      num_sat = NUM_W'(NUM_CAP);
    end else begin
      num_sat = numer[NUM_W-1:0];
    end
  end

  // Divide by DUTY_DIV: multiply by the reciprocal and keep the integer part
  assign quot_prod = (NUM_W+QRECIP_W)'(s3_num) * (NUM_W+QRECIP_W)'(DUTY_RECIP);
  assign quot      = quot_prod[QUOT_SHIFT +: DUTY_W];

  always_ff @(posedge clk) begin
    if (s1_open) begin
      s1_err   <= err;
      s1_integ <= acc_cl;
      s1_tag   <= tag_next;
    end
    if (s2_open) begin
      s2_pprod <= PPROD_W'(s1_err) * PPROD_W'($signed({1'b0, prop_gain}));
      s2_iprod <= IPROD_W'(s1_integ) * IPROD_W'($signed({1'b0, integ_gain}));
      s2_tag   <= s1_tag;
    end
    if (s3_open) begin
      s3_num <= num_sat;
      s3_tag <= s2_tag;
    end
    if (out_open) begin
      out_duty <= s3_tag.duty_valid ? quot : '0;
      out_tag  <= s3_tag;
    end
  end

  assign result.valid         = out_valid;
  assign result.duty_valid    = out_tag.duty_valid;
  assign result.duty          = out_duty;
  assign result.brake_command = out_tag.brake_command;
  assign result.speed_now     = out_tag.speed_now;

endmodule
